// ----- rtl/core/pip_pkg.sv -----
// Shared types and constants for the point-in-polygon ray cast core.
// Depends on nothing; every other file of the core imports it.
`timescale 1ns / 1ps

package pip_pkg;

  localparam int unsigned CoordW      = 16;
  localparam int unsigned IndexW      = 6;
  localparam int unsigned CountW      = 7;
  localparam int unsigned PAddrW      = 3;
  localparam int unsigned MinVertices = 3;
  localparam int          RayEndX     = 32767;

  // action field codes
  localparam logic ActLoad  = 1'b0;
  localparam logic ActQuery = 1'b1;

  // word index of the APB registers (paddr bit above the byte offset)
  localparam logic RegVertexCount = 1'b0;

  typedef logic signed [CoordW-1:0]   coord_t;
  typedef logic signed [CoordW:0]     diff_t;
  typedef logic signed [2*CoordW+1:0] prod_t;
  typedef logic signed [2*CoordW+2:0] cross_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  typedef struct packed {
    logic              action;
    logic [IndexW-1:0] vertex_index;
    coord_t            vertex_x;
    coord_t            vertex_y;
    coord_t            point_x;
    coord_t            point_y;
  } in_item_t;

  typedef struct packed {
    logic inside_res;
    logic on_edge_exit;
    logic too_few_vertices;
  } out_item_t;

  typedef struct packed {
    logic crossed;
    logic collinear;
    logic on_segment;
  } cross_res_t;

endpackage

// ----- rtl/core/pip_vstore.sv -----
// Vertex store: one write port, one registered read port.
// Depends on pip_pkg (vertex_t).
`timescale 1ns / 1ps

module pip_vstore import pip_pkg::*; #(
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  vertex_t          wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output vertex_t          rd_data_o
);

  vertex_t mem_q [Depth];
  vertex_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/pip_cross_eval.sv -----
// Edge versus ray decision: orientations, bounding box tests, crossing.
// Depends on pip_pkg (vertex_t, cross_t, diff_t, cross_res_t, RayEndX).
`timescale 1ns / 1ps

module pip_cross_eval import pip_pkg::*; (
  input  vertex_t    vtx_a_i,
  input  vertex_t    vtx_b_i,
  input  vertex_t    point_i,
  input  cross_t     v_abp_i,   // orientation value of (a, b, point)
  input  cross_t     v_abf_i,   // orientation value of (a, b, ray end)
  output cross_res_t res_o
);

  typedef enum logic [1:0] {
    TurnCol = 2'd0,
    TurnCw  = 2'd1,
    TurnCcw = 2'd2
  } turn_e;

  function automatic turn_e turn_of(cross_t v);
    turn_e t;
    if (v == '0) begin
      t = TurnCol;
    end else if (!v[$bits(cross_t)-1]) begin
      t = TurnCw;
    end else begin
      t = TurnCcw;
    end
    return t;
  endfunction

  // ray is horizontal: value reduces to -(s * d), sign from the factors
  function automatic turn_e turn_ray(diff_t s, diff_t d);
    turn_e t;
    if (s == '0 || d == '0) begin
      t = TurnCol;
    end else if (s[CoordW] != d[CoordW]) begin
      t = TurnCw;
    end else begin
      t = TurnCcw;
    end
    return t;
  endfunction

  // q inside the box spanned by u and w
  function automatic logic in_box(diff_t ux, diff_t uy, diff_t qx, diff_t qy,
                                  diff_t wx, diff_t wy);
    logic in_x;
    logic in_y;
    in_x = (qx <= ux || qx <= wx) && (qx >= ux || qx >= wx);
    in_y = (qy <= uy || qy <= wy) && (qy >= uy || qy >= wy);
    return in_x && in_y;
  endfunction

  diff_t ax, ay, bx, by, px, py, fx;
  diff_t s_ray, da, db;
  turn_e t1, t2, t3, t4;
  logic  w_apb, w_afb, w_pap, w_pbf;

  always_comb begin
    ax = diff_t'(vtx_a_i.x);
    ay = diff_t'(vtx_a_i.y);
    bx = diff_t'(vtx_b_i.x);
    by = diff_t'(vtx_b_i.y);
    px = diff_t'(point_i.x);
    py = diff_t'(point_i.y);
    fx = diff_t'(RayEndX);

    s_ray = fx - px;
    da    = ay - py;
    db    = by - py;

    t1 = turn_of(v_abp_i);
    t2 = turn_of(v_abf_i);
    t3 = turn_ray(s_ray, da);
    t4 = turn_ray(s_ray, db);

    w_apb = in_box(ax, ay, px, py, bx, by);
    w_afb = in_box(ax, ay, fx, py, bx, by);
    w_pap = in_box(px, py, ax, ay, fx, py);
    w_pbf = in_box(px, py, bx, by, fx, py);

    res_o.crossed    = (t1 != t2 && t3 != t4) ||
                       (t1 == TurnCol && w_apb) ||
                       (t2 == TurnCol && w_afb) ||
                       (t3 == TurnCol && w_pap) ||
                       (t4 == TurnCol && w_pbf);
    // turn(a, point, b) is collinear exactly when turn(a, b, point) is
    res_o.collinear  = (t1 == TurnCol);
    res_o.on_segment = w_apb;
  end

endmodule

// ----- rtl/core/point_in_polygon_ray_cast_core.sv -----
// Point-in-polygon ray cast core: vertex store, edge sequencer, shared multiplier.
// Depends on pip_pkg, pip_vstore and pip_cross_eval.
`timescale 1ns / 1ps
//
//  channel | signals                                   | dir | payload
//  --------+-------------------------------------------+-----+-------------------------
//  in      | in_valid_i / in_ready_o / in_item_i       | in  | in_item_t (load or query)
//  out     | out_valid_o / out_ready_i / out_item_o    | out | out_item_t (one per query)
//  cfg     | psel/penable/pwrite/paddr/pwdata/prdata   | in  | vertex_count at word 0
//
// Sequence: a vertex load is one transfer. A query with n >= 3 vertices
//   latches vertex 0 and fetches vertex 1 in StFirst, then walks each edge
//   through StMul1, StMul2 and StMul3 (three passes through the single 17x17
//   multiplier) and the decision state StEval, then hands off from StDone to the
//   output register. A query with fewer than three vertices goes straight to
//   StDone. A collinear hit stops the walk early.
// Reset: rst_ni is asynchronous, active low; it clears the sequencer, the output
//   valid and vertex_count. The vertex store is not cleared.
// Stalls: in_ready_o is high only while the sequencer is idle. A result waiting
//   in the output register does not block a new transfer in; the sequencer only
//   holds its own finished result until the output register frees up.

module point_in_polygon_ray_cast_core import pip_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_item_i,

  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_item_o,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AddrW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CntW  = AddrW + 1;                        // holds MAX_VERTICES + 1
  localparam int CmpW  = (CntW > CountW) ? CntW : CountW;  // room for count and max

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StFirst = 7'b0000010,
    StMul1  = 7'b0000100,
    StMul2  = 7'b0001000,
    StMul3  = 7'b0010000,
    StEval  = 7'b0100000,
    StDone  = 7'b1000000
  } state_e;

  state_e      state_q, state_d;
  logic [CountW-1:0] vertex_count_q;
  logic [CntW-1:0]   n_q, n_d;
  logic [CntW-1:0]   i_q, i_d;
  logic              parity_q, parity_d;
  logic              out_valid_q, out_valid_d;

  vertex_t     pt_q, pt_d;
  vertex_t     a_q, a_d;
  prod_t       prod_q, prod_d;
  prod_t       acc_q, acc_d;
  cross_t      v1_q, v1_d;
  cross_t      v2;
  out_item_t   res_q, res_d;
  out_item_t   out_item_q;

  // -------------------------------------------------------------------------
  // APB register port
  // -------------------------------------------------------------------------
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[PAddrW-1] == RegVertexCount);

  always_comb begin
    prdata = '0;
    if (paddr[PAddrW-1] == RegVertexCount) begin
      prdata = 32'(vertex_count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= '0;
    end else if (cfg_wr) begin
      vertex_count_q <= pwdata[CountW-1:0];
    end
  end

  // -------------------------------------------------------------------------
  // Input transfer decode
  // -------------------------------------------------------------------------
  logic          in_xfer;
  logic          load_xfer;
  logic          query_xfer;
  logic [CmpW-1:0] slot_ext;
  logic [CmpW-1:0] cnt_sat;
  logic          too_few;

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign load_xfer  = in_xfer && (in_item_i.action == ActLoad);
  assign query_xfer = in_xfer && (in_item_i.action == ActQuery);

  assign slot_ext = CmpW'(in_item_i.vertex_index);
  // count above the store depth saturates
  assign cnt_sat  = (CmpW'(vertex_count_q) > CmpW'(MAX_VERTICES)) ?
                    CmpW'(MAX_VERTICES) : CmpW'(vertex_count_q);
  assign too_few  = (cnt_sat < CmpW'(MinVertices));

  // -------------------------------------------------------------------------
  // Vertex store
  // -------------------------------------------------------------------------
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  vertex_t          wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  vertex_t          vtx_b;

  assign wr_en     = load_xfer && (slot_ext < CmpW'(MAX_VERTICES));
  assign wr_addr   = AddrW'(slot_ext);
  assign wr_data.x = in_item_i.vertex_x;
  assign wr_data.y = in_item_i.vertex_y;

  pip_vstore #(
    .Depth (MAX_VERTICES)
  ) u_vstore (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (vtx_b)
  );

  // -------------------------------------------------------------------------
  // Shared multiplier. Edge a->b, point p, ray end f = (RayEndX, p.y):
  //   Mul1: P3 = (bx-ax)*(py-by)   shared by both orientations
  //   Mul2: P1 = (by-ay)*(px-bx)   v1 = P1 - P3 -> turn(a, b, p)
  //   Mul3: P2 = (by-ay)*(fx-bx)   v2 = P2 - P3 -> turn(a, b, f)
  // -------------------------------------------------------------------------
  diff_t mul_a;
  diff_t mul_b;

  always_comb begin
    mul_a = diff_t'(vtx_b.y) - diff_t'(a_q.y);
    mul_b = '0;
    case (state_q)
      StMul1: begin
        mul_a = diff_t'(vtx_b.x) - diff_t'(a_q.x);
        mul_b = diff_t'(pt_q.y) - diff_t'(vtx_b.y);
      end
      StMul2: begin
        mul_b = diff_t'(pt_q.x) - diff_t'(vtx_b.x);
      end
      StMul3: begin
        mul_b = diff_t'(RayEndX) - diff_t'(vtx_b.x);
      end
      default: begin
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = prod_t'(mul_a) * prod_t'(mul_b);
  assign v2     = cross_t'(prod_q) - cross_t'(acc_q);

  cross_res_t cross_res;

  pip_cross_eval u_cross_eval (
    .vtx_a_i (a_q),
    .vtx_b_i (vtx_b),
    .point_i (pt_q),
    .v_abp_i (v1_q),
    .v_abf_i (v2),
    .res_o   (cross_res)
  );

  // -------------------------------------------------------------------------
  // Edge sequencer
  // -------------------------------------------------------------------------
  logic [CntW-1:0] next_b;   // vertex index for the following edge's b
  logic            last_edge;

  assign next_b    = (i_q + CntW'(2) == n_q) ? '0 : (i_q + CntW'(2));
  assign last_edge = (i_q == n_q - CntW'(1));

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    i_d      = i_q;
    parity_d = parity_q;
    pt_d     = pt_q;
    a_d      = a_q;
    acc_d    = acc_q;
    v1_d     = v1_q;
    res_d    = res_q;
    rd_en    = 1'b0;
    rd_addr  = '0;

    case (state_q)
      StIdle: begin
        // vertex 0 is fetched every idle cycle so a query can start at once
        rd_en = 1'b1;
        if (query_xfer) begin
          pt_d.x   = in_item_i.point_x;
          pt_d.y   = in_item_i.point_y;
          n_d      = CntW'(cnt_sat);
          i_d      = '0;
          parity_d = 1'b0;
          if (too_few) begin
            res_d.inside_res       = 1'b0;
            res_d.on_edge_exit     = 1'b0;
            res_d.too_few_vertices = 1'b1;
            state_d = StDone;
          end else begin
            state_d = StFirst;
          end
        end
      end
      StFirst: begin
        a_d     = vtx_b;
        rd_en   = 1'b1;
        rd_addr = AddrW'(1);
        state_d = StMul1;
      end
      StMul1: begin
        state_d = StMul2;
      end
      StMul2: begin
        acc_d   = prod_q;
        state_d = StMul3;
      end
      StMul3: begin
        v1_d    = cross_t'(prod_q) - cross_t'(acc_q);
        state_d = StEval;
      end
      StEval: begin
        if (cross_res.crossed && cross_res.collinear) begin
          res_d.inside_res       = cross_res.on_segment;
          res_d.on_edge_exit     = 1'b1;
          res_d.too_few_vertices = 1'b0;
          state_d = StDone;
        end else if (last_edge) begin
          res_d.inside_res       = parity_q ^ cross_res.crossed;
          res_d.on_edge_exit     = 1'b0;
          res_d.too_few_vertices = 1'b0;
          state_d = StDone;
        end else begin
          parity_d = parity_q ^ cross_res.crossed;
          a_d      = vtx_b;
          rd_en    = 1'b1;
          rd_addr  = AddrW'(next_b);
          i_d      = i_q + CntW'(1);
          state_d  = StMul1;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Output register
  // -------------------------------------------------------------------------
  logic out_load;

  assign out_load = (state_q == StDone) && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // -------------------------------------------------------------------------
  // Registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      n_q         <= '0;
      i_q         <= '0;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      i_q         <= i_d;
      parity_q    <= parity_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q   <= pt_d;
    a_q    <= a_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    v1_q   <= v1_d;
    res_q  <= res_d;
    if (out_load) begin
      out_item_q <= res_q;
    end
  end

endmodule
